### design/assert_macros.svh
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

### design/ksl_pkg.sv
package ksl_pkg;

    localparam int CAPACITY_DEF = 8;

    localparam int OP_W   = 3;
    localparam int KEY_W  = 32;
    localparam int PL_W   = 64;
    localparam int ST_W   = 3;
    localparam int POS_W  = 3;
    localparam int CNT_OUT_W = 4;

    localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE   = 3'd2;
    localparam logic [OP_W-1:0] OP_LOOKUP   = 3'd3;
    localparam logic [OP_W-1:0] OP_UPDATE   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
    localparam logic [ST_W-1:0] ST_DUP      = 3'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic signed [KEY_W-1:0] key;
        logic [PL_W-1:0]         payload;
    } req_t;

    typedef struct packed {
        logic [ST_W-1:0]      status;
        logic [POS_W-1:0]     position;
        logic [PL_W-1:0]      found_payload;
        logic [CNT_OUT_W-1:0] entry_count;
    } rsp_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [PL_W-1:0]         payload;
    } entry_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_cmd_t;

endpackage

### design/ksl_mem.sv
`include "assert_macros.svh"

module ksl_mem #(
    parameter int CAPACITY = ksl_pkg::CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ksl_pkg::mem_cmd_t  cmd,
    input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rd_addr,
    input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] wr_addr,
    input  ksl_pkg::entry_t    wr_data,
    output ksl_pkg::entry_t    rd_data
);

    ksl_pkg::entry_t mem_reg [CAPACITY];
    ksl_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

    // The sequencer never issues a read and a write together, so one entry is never read and written at once.
    `ASSERT_ALWAYS(a_no_rd_wr_overlap, clk, rst_n, !(cmd.rd_en && cmd.wr_en))
    `ASSERT_IMPLIES(a_rd_in_range, clk, rst_n, cmd.rd_en, int'(rd_addr) < CAPACITY)
    `ASSERT_IMPLIES(a_wr_in_range, clk, rst_n, cmd.wr_en, int'(wr_addr) < CAPACITY)

endmodule

### design/ksl_ctrl.sv
`include "assert_macros.svh"

module ksl_ctrl #(
    parameter int CAPACITY = ksl_pkg::CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  ksl_pkg::req_t      req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output ksl_pkg::rsp_t      rsp,
    output ksl_pkg::mem_cmd_t  mem_cmd,
    output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] mem_rd_addr,
    output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] mem_wr_addr,
    output ksl_pkg::entry_t    mem_wr_data,
    input  ksl_pkg::entry_t    mem_rd_data
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int POS_W = ksl_pkg::POS_W;
    localparam int CNT_OUT_W = ksl_pkg::CNT_OUT_W;
    localparam int PL_W = ksl_pkg::PL_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_WRITE,
        S_DONE
    } state_t;

    state_t                          state_reg, state_next;
    ksl_pkg::req_t                   req_reg, req_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [IDX_W-1:0]                ptr_reg, ptr_next;
    logic                            hit_reg, hit_next;
    logic [IDX_W-1:0]                hit_idx_reg, hit_idx_next;
    logic [PL_W-1:0]                 hit_pl_reg, hit_pl_next;
    ksl_pkg::rsp_t                   res_reg, res_next;
    ksl_pkg::rsp_t                   rsp_reg, rsp_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    logic                            is_insert;
    logic                            is_full;

    assign is_insert = (req_reg.opcode == ksl_pkg::OP_INS_TAIL)
                    || (req_reg.opcode == ksl_pkg::OP_INS_HEAD);
    assign is_full = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_pl_next    = hit_pl_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        mem_cmd        = '0;
        mem_rd_addr    = ptr_reg;
        mem_wr_addr    = ptr_reg;
        mem_wr_data    = '{key: req_reg.key, payload: req_reg.payload};

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    ptr_next = '0;
                    hit_next = 1'b0;
                    if (count_reg == '0)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        state_next = S_SEARCH_RD;
                    end
                end
            end
            S_SEARCH_RD:
            begin
                mem_cmd.rd_en = 1'b1;
                state_next    = S_SEARCH_CMP;
            end
            S_SEARCH_CMP:
            begin
                if (mem_rd_data.key == req_reg.key)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = ptr_reg;
                    hit_pl_next  = mem_rd_data.payload;
                    state_next   = S_DECIDE;
                end
                else if ((CNT_W'(ptr_reg) + CNT_W'(1)) == count_reg)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    ptr_next   = ptr_reg + IDX_W'(1);
                    state_next = S_SEARCH_RD;
                end
            end
            S_DECIDE:
            begin
                res_next               = '0;
                res_next.status        = ksl_pkg::ST_NOTFOUND;
                state_next             = S_DONE;
                if (is_insert)
                begin
                    if (is_full)
                    begin
                        res_next.status = ksl_pkg::ST_FULL;
                    end
                    else if (hit_reg)
                    begin
                        res_next.status = ksl_pkg::ST_DUP;
                    end
                    else
                    begin
                        res_next.status = ksl_pkg::ST_OK;
                        count_next      = count_reg + CNT_W'(1);
                        if (req_reg.opcode == ksl_pkg::OP_INS_TAIL)
                        begin
                            res_next.position = POS_W'(count_reg);
                            ptr_next          = IDX_W'(count_reg);
                            state_next        = S_WRITE;
                        end
                        else if (count_reg == '0)
                        begin
                            ptr_next   = '0;
                            state_next = S_WRITE;
                        end
                        else
                        begin
                            ptr_next   = IDX_W'(count_reg);
                            state_next = S_SHIFT_RD;
                        end
                    end
                end
                else if (req_reg.opcode == ksl_pkg::OP_REMOVE)
                begin
                    if (count_reg == '0)
                    begin
                        res_next.status = ksl_pkg::ST_EMPTY;
                    end
                    else if (hit_reg)
                    begin
                        res_next.status   = ksl_pkg::ST_OK;
                        res_next.position = POS_W'(hit_idx_reg);
                        count_next        = count_reg - CNT_W'(1);
                        ptr_next          = hit_idx_reg;
                        if ((CNT_W'(hit_idx_reg) + CNT_W'(1)) != count_reg)
                        begin
                            state_next = S_SHIFT_RD;
                        end
                    end
                end
                else if (req_reg.opcode == ksl_pkg::OP_LOOKUP)
                begin
                    if (hit_reg)
                    begin
                        res_next.status        = ksl_pkg::ST_OK;
                        res_next.position      = POS_W'(hit_idx_reg);
                        res_next.found_payload = hit_pl_reg;
                    end
                end
                else if (req_reg.opcode == ksl_pkg::OP_UPDATE)
                begin
                    if (hit_reg)
                    begin
                        res_next.status   = ksl_pkg::ST_OK;
                        res_next.position = POS_W'(hit_idx_reg);
                        ptr_next          = hit_idx_reg;
                        state_next        = S_WRITE;
                    end
                end
            end
            S_SHIFT_RD:
            begin
                mem_cmd.rd_en = 1'b1;
                if (req_reg.opcode == ksl_pkg::OP_INS_HEAD)
                begin
                    mem_rd_addr = ptr_reg - IDX_W'(1);
                end
                else
                begin
                    mem_rd_addr = ptr_reg + IDX_W'(1);
                end
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                mem_cmd.wr_en = 1'b1;
                mem_wr_data   = mem_rd_data;
                if (req_reg.opcode == ksl_pkg::OP_INS_HEAD)
                begin
                    ptr_next = ptr_reg - IDX_W'(1);
                    if (ptr_reg == IDX_W'(1))
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_SHIFT_RD;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + IDX_W'(1);
                    if ((CNT_W'(ptr_reg) + CNT_W'(1)) == count_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SHIFT_RD;
                    end
                end
            end
            S_WRITE:
            begin
                mem_cmd.wr_en = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!(rsp_valid_reg && rsp_stall))
                begin
                    rsp_next             = res_reg;
                    rsp_next.entry_count = CNT_OUT_W'(count_reg);
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            ptr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            hit_reg       <= hit_next;
            ptr_reg       <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        hit_idx_reg <= hit_idx_next;
        hit_pl_reg  <= hit_pl_next;
        res_reg     <= res_next;
        rsp_reg     <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, int'(count_reg) <= CAPACITY)
    `ASSERT_IMPLIES(a_rsp_count, clk, rst_n, $rose(rsp_valid_reg),
        rsp_reg.entry_count == CNT_OUT_W'(count_reg))
    `ASSERT_IMPLIES(a_fail_zero, clk, rst_n,
        rsp_valid_reg && (rsp_reg.status != ksl_pkg::ST_OK),
        (rsp_reg.position == '0) && (rsp_reg.found_payload == '0))

endmodule

### design/keyed_sequential_list_top.sv
// Ordered table of up to CAPACITY records with unique keys, held in a
// synchronous memory with one read and one write per cycle. A request word
// is taken only while the sequencer is idle; it then scans the table one
// entry at a time (read, then compare) until the key matches or the valid
// entries run out, and moves entries one place at a time (read, then write)
// for an insert at the head or a remove. The longest request is an insert at
// the head of a table holding CAPACITY-1 entries. The result word waits in
// an output register, so a new request is taken while the previous result is
// still stalled.
module keyed_sequential_list_top #(
    parameter int CAPACITY = ksl_pkg::CAPACITY_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  ksl_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output ksl_pkg::rsp_t  rsp
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    ksl_pkg::mem_cmd_t  mem_cmd;
    logic [IDX_W-1:0]   mem_rd_addr;
    logic [IDX_W-1:0]   mem_wr_addr;
    ksl_pkg::entry_t    mem_wr_data;
    ksl_pkg::entry_t    mem_rd_data;

    ksl_mem #(
        .CAPACITY (CAPACITY)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mem_cmd),
        .rd_addr (mem_rd_addr),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    ksl_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .mem_cmd     (mem_cmd),
        .mem_rd_addr (mem_rd_addr),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_data (mem_rd_data)
    );

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int CAP           = ksl_pkg::CAPACITY_DEF;
    localparam int POOL_SIZE     = 10;
    localparam int MAX_IDLE      = 18;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int TAIL_CYCLES   = 4 * CAP + 12;

    localparam logic [ksl_pkg::OP_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [ksl_pkg::OP_W-1:0] OP_RSVD_7 = 3'd7;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_stall;
    ksl_pkg::req_t req       = '0;
    logic          rsp_valid;
    logic          rsp_stall = 1'b0;
    ksl_pkg::rsp_t rsp;

    logic [ksl_pkg::KEY_W-1:0] shadow_keys[CAP];
    logic [ksl_pkg::PL_W-1:0]  shadow_payloads[CAP];
    int                        shadow_count = 0;

    ksl_pkg::rsp_t             expected_rsp_q[$];
    logic [ksl_pkg::KEY_W-1:0] key_pool[POOL_SIZE];
    bit                        idle_on = 1'b1;
    int                        fail_count = 0;
    int                        rsp_wait = 0;
    int                        quiet_cycles = 0;

    keyed_sequential_list_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int shadow_find(input logic [ksl_pkg::KEY_W-1:0] k);
        for (int i = 0; i < shadow_count; i++)
        begin
            if (shadow_keys[i] == k)
                return i;
        end
        return CAP;
    endfunction

    // Applies one request word to the shadow table and returns the expected result word.
    function automatic ksl_pkg::rsp_t shadow_apply(input ksl_pkg::req_t w);
        ksl_pkg::rsp_t r;
        int            idx;
        r = '0;
        r.status = ksl_pkg::ST_OK;
        case (w.opcode)
            ksl_pkg::OP_INS_TAIL, ksl_pkg::OP_INS_HEAD:
            begin
                if (shadow_count >= CAP)
                    r.status = ksl_pkg::ST_FULL;
                else if (shadow_find(w.key) != CAP)
                    r.status = ksl_pkg::ST_DUP;
                else if (w.opcode == ksl_pkg::OP_INS_TAIL)
                begin
                    r.position = shadow_count[ksl_pkg::POS_W-1:0];
                    shadow_keys[shadow_count] = w.key;
                    shadow_payloads[shadow_count] = w.payload;
                    shadow_count++;
                end
                else
                begin
                    for (int i = shadow_count; i > 0; i--)
                    begin
                        shadow_keys[i] = shadow_keys[i-1];
                        shadow_payloads[i] = shadow_payloads[i-1];
                    end
                    shadow_keys[0] = w.key;
                    shadow_payloads[0] = w.payload;
                    shadow_count++;
                end
            end
            ksl_pkg::OP_REMOVE:
            begin
                if (shadow_count == 0)
                    r.status = ksl_pkg::ST_EMPTY;
                else
                begin
                    idx = shadow_find(w.key);
                    if (idx == CAP)
                        r.status = ksl_pkg::ST_NOTFOUND;
                    else
                    begin
                        for (int i = idx; i + 1 < shadow_count; i++)
                        begin
                            shadow_keys[i] = shadow_keys[i+1];
                            shadow_payloads[i] = shadow_payloads[i+1];
                        end
                        shadow_count--;
                        r.position = idx[ksl_pkg::POS_W-1:0];
                    end
                end
            end
            ksl_pkg::OP_LOOKUP:
            begin
                idx = shadow_find(w.key);
                if (idx == CAP)
                    r.status = ksl_pkg::ST_NOTFOUND;
                else
                begin
                    r.position = idx[ksl_pkg::POS_W-1:0];
                    r.found_payload = shadow_payloads[idx];
                end
            end
            ksl_pkg::OP_UPDATE:
            begin
                idx = shadow_find(w.key);
                if (idx == CAP)
                    r.status = ksl_pkg::ST_NOTFOUND;
                else
                begin
                    shadow_payloads[idx] = w.payload;
                    r.position = idx[ksl_pkg::POS_W-1:0];
                end
            end
            default:
                r.status = ksl_pkg::ST_NOTFOUND;
        endcase
        r.entry_count = shadow_count[ksl_pkg::CNT_OUT_W-1:0];
        return r;
    endfunction

    // Valid is held high from one word to the next when no gap is drawn.
    task automatic send_word(input ksl_pkg::req_t w);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= w;
        do
            @(posedge clk);
        while (req_stall);
        expected_rsp_q.push_back(shadow_apply(w));
    endtask

    task automatic send_op(input logic [ksl_pkg::OP_W-1:0] op,
                           input logic [ksl_pkg::KEY_W-1:0] k,
                           input logic [ksl_pkg::PL_W-1:0] pl);
        ksl_pkg::req_t w;
        w.opcode = op;
        w.key = k;
        w.payload = pl;
        send_word(w);
    endtask

    task automatic wait_drain();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_rsp_q.size() != 0);
    endtask

    function automatic ksl_pkg::req_t random_word(input int ins_pct, input int rem_pct);
        ksl_pkg::req_t w;
        int            r;
        r = $urandom_range(0, 99);
        if (r < ins_pct)
            w.opcode = $urandom_range(0, 1) ? ksl_pkg::OP_INS_HEAD : ksl_pkg::OP_INS_TAIL;
        else if (r < ins_pct + rem_pct)
            w.opcode = ksl_pkg::OP_REMOVE;
        else if (r < 96)
            w.opcode = $urandom_range(0, 1) ? ksl_pkg::OP_LOOKUP : ksl_pkg::OP_UPDATE;
        else
            w.opcode = ksl_pkg::OP_W'($urandom_range(OP_RSVD_5, OP_RSVD_7));
        if ($urandom_range(0, 99) < 88)
            w.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            w.key = $urandom;
        w.payload = {$urandom, $urandom};
        return w;
    endfunction

    task automatic refresh_key_pool();
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        if ($urandom_range(0, 1))
        begin
            key_pool[0] = 32'h8000_0000;
            key_pool[1] = 32'h7FFF_FFFF;
            key_pool[2] = 32'h0000_0000;
            key_pool[3] = 32'hFFFF_FFFF;
        end
    endtask

    task automatic test_empty_table();
        send_op(ksl_pkg::OP_REMOVE, 32'd5, '0);
        send_op(ksl_pkg::OP_LOOKUP, 32'd5, '1);
        send_op(ksl_pkg::OP_UPDATE, 32'd5, '1);
        send_op(OP_RSVD_5, 32'd5, '1);
        send_op(OP_RSVD_7, 32'hFFFF_FFFF, '1);
    endtask

    task automatic test_fill_to_capacity();
        send_op(ksl_pkg::OP_INS_TAIL, 32'h8000_0000, '1);
        send_op(ksl_pkg::OP_INS_HEAD, 32'h7FFF_FFFF, '0);
        send_op(ksl_pkg::OP_INS_TAIL, 32'h0000_0000, 64'hA5A5_A5A5_A5A5_A5A5);
        send_op(ksl_pkg::OP_INS_TAIL, 32'hFFFF_FFFF, 64'h5A5A_5A5A_5A5A_5A5A);
        send_op(ksl_pkg::OP_INS_TAIL, 32'h0000_0000, 64'h1);
        send_op(ksl_pkg::OP_INS_HEAD, 32'h7FFF_FFFF, 64'h2);
        send_op(ksl_pkg::OP_INS_HEAD, 32'd1, 64'h11);
        send_op(ksl_pkg::OP_INS_TAIL, 32'd2, 64'h22);
        send_op(ksl_pkg::OP_INS_HEAD, 32'd3, 64'h33);
        send_op(ksl_pkg::OP_INS_TAIL, 32'd4, 64'h44);
        send_op(ksl_pkg::OP_INS_TAIL, 32'd5, 64'h55);
        send_op(ksl_pkg::OP_INS_HEAD, 32'h0000_0000, 64'h66);
    endtask

    task automatic test_search_ops();
        send_op(ksl_pkg::OP_LOOKUP, 32'd3, '0);
        send_op(ksl_pkg::OP_LOOKUP, 32'd4, '1);
        send_op(ksl_pkg::OP_UPDATE, 32'h0000_0000, 64'hDEAD_BEEF_0123_4567);
        send_op(ksl_pkg::OP_LOOKUP, 32'h0000_0000, '0);
        send_op(ksl_pkg::OP_LOOKUP, 32'd9, '0);
        send_op(ksl_pkg::OP_REMOVE, 32'd9, '0);
        send_op(ksl_pkg::OP_REMOVE, 32'h0000_0000, '0);
        send_op(ksl_pkg::OP_REMOVE, 32'd4, '0);
        send_op(ksl_pkg::OP_REMOVE, 32'd3, '0);
    endtask

    // Phases lean toward filling, draining or a balanced mix, so the table
    // keeps swinging between empty and full.
    task automatic test_random_traffic();
        int ins_pct;
        int rem_pct;
        for (int phase = 0; phase < 20; phase++)
        begin
            if (phase % 5 == 0)
                refresh_key_pool();
            idle_on = (phase % 4 != 3);
            case (phase % 3)
                0:
                begin
                    ins_pct = 60;
                    rem_pct = 15;
                end
                1:
                begin
                    ins_pct = 15;
                    rem_pct = 60;
                end
                default:
                begin
                    ins_pct = 35;
                    rem_pct = 30;
                end
            endcase
            if (phase == 10)
                wait_drain();
            for (int n = 0; n < 100; n++)
                send_word(random_word(ins_pct, rem_pct));
        end
        idle_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        ksl_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                $error("result word with no request pending");
                fail_count++;
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    fail_count++;
                end
                if (rsp.position !== want.position)
                begin
                    $error("position: expected %0d, got %0d", want.position, rsp.position);
                    fail_count++;
                end
                if (rsp.found_payload !== want.found_payload)
                begin
                    $error("found_payload: expected %h, got %h",
                           want.found_payload, rsp.found_payload);
                    fail_count++;
                end
                if (rsp.entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, rsp.entry_count);
                    fail_count++;
                end
            end
            rsp_wait = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        end
        else if (rsp_wait > 0)
            rsp_wait--;
        rsp_stall <= (rsp_wait != 0);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_fill_to_capacity();
        wait_drain();
        test_search_ops();
        test_random_traffic();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_rsp_q.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
